// File: hdl/dmx512_spi_frame_builder_macros.svh
// Assertion macros shared by the frame builder modules.
// Depends on nothing; included by the files that check their own logic.
`ifndef DMX512_SPI_FRAME_BUILDER_MACROS_SVH
`define DMX512_SPI_FRAME_BUILDER_MACROS_SVH

`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define DSFB_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Condition must never be seen at a clock edge outside reset.
`define DSFB_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define DSFB_ASSERT(label, clk, rst, prop, msg)
`define DSFB_ASSERT_NEVER(label, clk, rst, cond, msg)
`endif

`endif

// File: hdl/dsfb_pkg.sv
// Types, codes and frame layout constants of the DMX512 SPI frame builder.
// Depends on nothing; every module of the block uses it.
`timescale 1ns / 1ps

package dsfb_pkg;

   // Frame layout, in SPI bytes (one byte per DMX bit time).
   localparam int MTBP_LEN  = 2;
   localparam int BREAK_LEN = 23;
   localparam int MAB_LEN   = 3;
   localparam int MAX_SLOTS = 512;

   localparam int FRAME_LEN      = 11;
   localparam int HDR_FILL_LEN   = MTBP_LEN + BREAK_LEN + MAB_LEN;
   localparam int RUN_HEADER_LEN = HDR_FILL_LEN + FRAME_LEN;

   localparam int SLOT_CNT_W = $clog2(MAX_SLOTS + 1);
   localparam int POS_W      = $clog2(RUN_HEADER_LEN + 1);

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Input action codes.
   localparam logic [1:0] ACT_BEGIN  = 2'd0;
   localparam logic [1:0] ACT_SLOT   = 2'd1;
   localparam logic [1:0] ACT_END    = 2'd2;
   localparam logic [1:0] ACT_UNUSED = 2'd3;

   // Register indexes of the configuration port.
   localparam logic [2:0] CSR_IDLE_FILL  = 3'd0;
   localparam logic [2:0] CSR_BREAK_FILL = 3'd1;
   localparam logic [2:0] CSR_MAB_FILL   = 3'd2;
   localparam logic [2:0] CSR_START_BIT  = 3'd3;
   localparam logic [2:0] CSR_STOP_BIT   = 3'd4;

   localparam logic [7:0] BYTE_ONES  = 8'hFF;
   localparam logic [7:0] BYTE_ZEROS = 8'h00;

   typedef enum logic [1:0] {
      OP_HEADER,
      OP_FRAME,
      OP_PAD
   } op_type;

   // One run of bytes for the back end to send.
   typedef struct packed {
      op_type     op;
      logic [7:0] level;
      logic [2:0] pad_len;
   } cmd_type;

   typedef struct packed {
      logic [7:0] idle_fill;
      logic [7:0] break_fill;
      logic [7:0] mab_fill;
      logic [7:0] start_bit;
      logic [7:0] stop_bit;
   } cfg_type;

endpackage

// File: hdl/dsfb_front.sv
// Front end: classifies incoming items, keeps the slot count and byte phase,
// and hands byte runs to the queue. Depends on dsfb_pkg.
`timescale 1ns / 1ps

module dsfb_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_action,
   input  logic [7:0]         req_slot_value,
   output logic               push_valid,
   input  logic               push_ready,
   output dsfb_pkg::cmd_type  push_cmd
);

   logic [dsfb_pkg::SLOT_CNT_W-1:0] slot_count_ff, slot_count_in;
   logic [2:0]                      byte_phase_ff, byte_phase_in;
   logic                            accept;
   logic [2:0]                      pad_len;

   // Dropped and ignored items are still taken, so ready follows the queue.
   assign req_ready = push_ready;
   assign accept    = req_valid && req_ready;
   assign pad_len   = 3'd0 - byte_phase_ff;

   always_comb begin
      push_valid       = 1'b0;
      push_cmd.op      = dsfb_pkg::OP_FRAME;
      push_cmd.level   = req_slot_value;
      push_cmd.pad_len = pad_len;
      slot_count_in    = slot_count_ff;
      byte_phase_in    = byte_phase_ff;
      unique case (req_action)
         dsfb_pkg::ACT_BEGIN: begin
            push_valid     = accept;
            push_cmd.op    = dsfb_pkg::OP_HEADER;
            push_cmd.level = dsfb_pkg::BYTE_ZEROS;
            if (accept) begin
               slot_count_in = '0;
               byte_phase_in = byte_phase_ff + 3'(dsfb_pkg::RUN_HEADER_LEN);
            end
         end
         dsfb_pkg::ACT_SLOT: begin
            if (slot_count_ff < dsfb_pkg::SLOT_CNT_W'(dsfb_pkg::MAX_SLOTS)) begin
               push_valid = accept;
               if (accept) begin
                  slot_count_in = slot_count_ff + 1'b1;
                  byte_phase_in = byte_phase_ff + 3'(dsfb_pkg::FRAME_LEN);
               end
            end
         end
         dsfb_pkg::ACT_END: begin
            push_cmd.op = dsfb_pkg::OP_PAD;
            // An already aligned stream needs no padding and sends nothing.
            if (pad_len != 3'd0) begin
               push_valid = accept;
               if (accept) begin
                  byte_phase_in = 3'd0;
               end
            end
         end
         dsfb_pkg::ACT_UNUSED: begin
            push_valid = 1'b0;
         end
         default: begin
            push_valid = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_count_ff <= '0;
         byte_phase_ff <= '0;
      end else begin
         slot_count_ff <= slot_count_in;
         byte_phase_ff <= byte_phase_in;
      end
   end

endmodule

// File: hdl/dsfb_queue.sv
// Short command queue between the front and back ends.
// Depends on dsfb_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "dmx512_spi_frame_builder_macros.svh"

module dsfb_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  dsfb_pkg::cmd_type  push_cmd,
   output logic               pop_valid,
   input  logic               pop,
   output dsfb_pkg::cmd_type  pop_cmd
);

   dsfb_pkg::cmd_type               entry_ff [dsfb_pkg::QUEUE_DEPTH];
   logic [dsfb_pkg::QPTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [dsfb_pkg::QPTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [dsfb_pkg::QCNT_W-1:0]     count_ff, count_in;
   logic                            do_push;
   logic                            do_pop;

   assign push_ready = count_ff != dsfb_pkg::QCNT_W'(dsfb_pkg::QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_cmd    = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == dsfb_pkg::QPTR_W'(dsfb_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == dsfb_pkg::QPTR_W'(dsfb_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   `DSFB_ASSERT_NEVER(a_queue_overfill, clock, reset,
      count_ff > dsfb_pkg::QCNT_W'(dsfb_pkg::QUEUE_DEPTH), "queue holds more than its depth")
   `DSFB_ASSERT_NEVER(a_queue_pop_empty, clock, reset, pop && !pop_valid,
      "back end pops an empty queue")
   `DSFB_ASSERT(a_queue_count_step, clock, reset,
      (do_push && !do_pop) |=> (count_ff == $past(count_ff) + 1'b1),
      "queue count did not follow a push")

endmodule

// File: hdl/dsfb_back.sv
// Back end: expands each queued command into SPI bytes, one per cycle while
// the receiver takes them, into the result register. Depends on dsfb_pkg and the macro header.
`timescale 1ns / 1ps
`include "dmx512_spi_frame_builder_macros.svh"

module dsfb_back (
   input  logic               clock,
   input  logic               reset,
   input  dsfb_pkg::cfg_type  cfg,
   input  logic               cmd_valid,
   input  dsfb_pkg::cmd_type  cmd,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [7:0]         rsp_spi_byte,
   output logic               rsp_last_of_run
);

   localparam int POS_W = dsfb_pkg::POS_W;
   localparam logic [POS_W-1:0] MTBP_END  = POS_W'(dsfb_pkg::MTBP_LEN);
   localparam logic [POS_W-1:0] BREAK_END = POS_W'(dsfb_pkg::MTBP_LEN + dsfb_pkg::BREAK_LEN);
   localparam logic [POS_W-1:0] FILL_END  = POS_W'(dsfb_pkg::HDR_FILL_LEN);

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [POS_W-1:0] run_len;
   logic [POS_W-1:0] frame_pos;
   logic [2:0]       bit_index;
   logic             advance;
   logic             last;
   logic [7:0]       byte_val;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       rsp_byte_ff;
   logic             rsp_last_ff;

   always_comb begin
      unique case (cmd.op)
         dsfb_pkg::OP_HEADER: run_len = POS_W'(dsfb_pkg::RUN_HEADER_LEN);
         dsfb_pkg::OP_FRAME:  run_len = POS_W'(dsfb_pkg::FRAME_LEN);
         dsfb_pkg::OP_PAD:    run_len = POS_W'(cmd.pad_len);
         default:             run_len = POS_W'(dsfb_pkg::FRAME_LEN);
      endcase
   end

   // The slot frame sits after the fill bytes in a header run.
   assign frame_pos = (cmd.op == dsfb_pkg::OP_HEADER) ? pos_ff - FILL_END : pos_ff;
   assign bit_index = 3'(frame_pos - 1'b1);

   always_comb begin
      if (cmd.op == dsfb_pkg::OP_PAD) begin
         byte_val = dsfb_pkg::BYTE_ZEROS;
      end else if (cmd.op == dsfb_pkg::OP_HEADER && pos_ff < MTBP_END) begin
         byte_val = cfg.idle_fill;
      end else if (cmd.op == dsfb_pkg::OP_HEADER && pos_ff < BREAK_END) begin
         byte_val = cfg.break_fill;
      end else if (cmd.op == dsfb_pkg::OP_HEADER && pos_ff < FILL_END) begin
         byte_val = cfg.mab_fill;
      end else if (frame_pos == '0) begin
         byte_val = cfg.start_bit;
      end else if (frame_pos < POS_W'(9)) begin
         byte_val = cmd.level[bit_index] ? dsfb_pkg::BYTE_ONES : dsfb_pkg::BYTE_ZEROS;
      end else begin
         byte_val = cfg.stop_bit;
      end
   end

   assign advance = cmd_valid && (!rsp_valid_ff || rsp_ready);
   assign last    = pos_ff == run_len - 1'b1;
   assign pop     = advance && last;

   always_comb begin
      pos_in       = pos_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (advance) begin
         pos_in       = last ? '0 : pos_ff + 1'b1;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_byte_ff <= byte_val;
         rsp_last_ff <= last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_spi_byte    = rsp_byte_ff;
   assign rsp_last_of_run = rsp_last_ff;

   `DSFB_ASSERT(a_back_pop_marks_last, clock, reset,
      pop |=> (rsp_valid_ff && rsp_last_ff), "run ended without a last-of-run byte")
   `DSFB_ASSERT_NEVER(a_back_pos_in_run, clock, reset,
      cmd_valid && (pos_ff >= run_len), "byte position past the end of its run")
   `DSFB_ASSERT(a_back_pos_idle, clock, reset,
      !cmd_valid |-> (pos_ff == '0), "byte position left mid-run with no command")

endmodule

// File: hdl/dmx512_spi_frame_builder.sv
// DMX512 frame builder producing an SPI byte stream, one byte per DMX bit.
// Channels:
//   req_*  input items: action (begin, slot, end) and slot_value.
//   rsp_*  result bytes: rsp_spi_byte, with rsp_last_of_run on the final
//          byte that an item causes.
//   csr_*  register writes by index; always ready.
// A begin item gives 39 bytes (fill bytes then a zero start-code frame), a
// slot gives 11 bytes, an end gives 0 to 7 zero pad bytes. Slots beyond the
// maximum count, unused actions and aligned ends give nothing.
// The first byte of an item passes through the command queue and then the
// result register before it is presented on rsp_*. The back end sends one
// byte per cycle through the result register while the receiver takes them.
// A two-entry command queue lets the next items be taken while a run is
// still being sent.
// Reset clears the slot count, byte phase, queue and result valid flag and
// loads the register defaults. When the receiver stalls, the result byte
// holds, the queue fills and then req_ready falls until it drains.
// Depends on dsfb_pkg, dsfb_front, dsfb_queue and dsfb_back.
`timescale 1ns / 1ps

module dmx512_spi_frame_builder (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_action,
   input  logic [7:0] req_slot_value,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_spi_byte,
   output logic       rsp_last_of_run,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [2:0] csr_index,
   input  logic [7:0] csr_wdata
);

   dsfb_pkg::cfg_type cfg_ff, cfg_in;
   dsfb_pkg::cmd_type push_cmd;
   dsfb_pkg::cmd_type pop_cmd;
   logic              push_valid;
   logic              push_ready;
   logic              pop_valid;
   logic              pop;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            dsfb_pkg::CSR_IDLE_FILL:  cfg_in.idle_fill  = csr_wdata;
            dsfb_pkg::CSR_BREAK_FILL: cfg_in.break_fill = csr_wdata;
            dsfb_pkg::CSR_MAB_FILL:   cfg_in.mab_fill   = csr_wdata;
            dsfb_pkg::CSR_START_BIT:  cfg_in.start_bit  = csr_wdata;
            dsfb_pkg::CSR_STOP_BIT:   cfg_in.stop_bit   = csr_wdata;
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.idle_fill  <= 8'hFF;
         cfg_ff.break_fill <= 8'h00;
         cfg_ff.mab_fill   <= 8'hFF;
         cfg_ff.start_bit  <= 8'h00;
         cfg_ff.stop_bit   <= 8'hFF;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   dsfb_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_action     (req_action),
      .req_slot_value (req_slot_value),
      .push_valid     (push_valid),
      .push_ready     (push_ready),
      .push_cmd       (push_cmd)
   );

   dsfb_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .pop_valid  (pop_valid),
      .pop        (pop),
      .pop_cmd    (pop_cmd)
   );

   dsfb_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .cmd_valid       (pop_valid),
      .cmd             (pop_cmd),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_spi_byte    (rsp_spi_byte),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule
